@@ rtl/core/erd_pkg.sv @@
// Package for the escape run-length decoder.
// Widths, register indexes, reset values and the decode phase type.
// No dependencies.
package erd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP = 1'b1;

    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] HEADER_SKIP_RESET = 8'd81;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_ESC   = 3'b010,
        PH_COUNT = 3'b100
    } t_phase;

endpackage

@@ rtl/core/erd_byte_if.sv @@
// Input channel of the escape run-length decoder: one packed byte per word.
// Depends on erd_pkg.
interface erd_byte_if
    import erd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink   (input valid, input packed_byte, output ready);
endinterface

@@ rtl/core/erd_run_if.sv @@
// Output channel of the escape run-length decoder: one run (value, length) per word.
// Depends on erd_pkg.
interface erd_run_if
    import erd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] run_value;
    logic [BYTE_W-1:0] run_length;

    modport source (output valid, output run_value, output run_length, input ready);
    modport sink   (input valid, input run_value, input run_length, output ready);
endinterface

@@ rtl/core/escape_rle_run_decoder.sv @@
// Escape run-length decoder: the run word is registered and appears in the cycle after the byte that completes it.
// Throughput 1 byte per cycle while the run word is not stalled; the decode phase, the header counter and the
// run trim all resolve in the same cycle ahead of the result register.
// A new byte is taken while a run word is held if that word leaves this cycle.
// Synchronous active-low reset: phase idle, counter zero, escape 0, header skip 81.
// Depends on erd_pkg, erd_byte_if, erd_run_if.
module escape_rle_run_decoder
    import erd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    erd_byte_if.sink             i_in,
    erd_run_if.source            o_out
);

    logic [BYTE_W-1:0] r_escape_code;
    logic [BYTE_W-1:0] r_header_skip;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_held;
    logic [BYTE_W-1:0] n_held;
    logic [BYTE_W-1:0] r_decoded;
    logic [BYTE_W-1:0] n_decoded;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_run_value;
    logic [BYTE_W-1:0] r_run_length;

    logic              accept;
    logic              run_go;
    logic [BYTE_W-1:0] run_val;
    logic [BYTE_W-1:0] run_cnt;
    logic [BYTE_W-1:0] left;
    logic              emit;
    logic [BYTE_W-1:0] emit_len;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        run_go  = 1'b0;
        run_val = i_in.packed_byte;
        run_cnt = 8'd1;
        case (r_phase)
            PH_ESC: begin
                if (i_in.packed_byte == r_escape_code) begin
                    n_phase = PH_IDLE;
                    run_go  = 1'b1;
                end else begin
                    n_held  = i_in.packed_byte;
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n_phase = PH_IDLE;
                run_go  = 1'b1;
                run_val = r_held;
                run_cnt = i_in.packed_byte;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_in.packed_byte == r_escape_code) begin
                    n_phase = PH_ESC;
                end else begin
                    run_go = 1'b1;
                end
            end
        endcase
    end

    // header trim: bytes still to drop, then what survives
    always_comb begin
        left      = (r_decoded >= r_header_skip) ? 8'd0 : r_header_skip - r_decoded;
        n_decoded = r_decoded;
        emit      = 1'b0;
        emit_len  = run_cnt - left;
        if (run_go && run_cnt != 8'd0) begin
            if (run_cnt <= left) begin
                n_decoded = r_decoded + run_cnt;
            end else begin
                n_decoded = r_header_skip;
                emit      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_code <= ESCAPE_CODE_RESET;
            r_header_skip <= HEADER_SKIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ESCAPE_CODE: r_escape_code <= i_cfg_data;
                CFG_HEADER_SKIP: r_header_skip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_held      <= '0;
            r_decoded   <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_decoded   <= n_decoded;
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_run_value  <= run_val;
            r_run_length <= emit_len;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.run_value  = r_run_value;
    assign o_out.run_length = r_run_length;

endmodule

@@ rtl/core/erd_checker.sv @@
// Port-level checks for escape_rle_run_decoder, attached by bind.
// Depends on erd_pkg and the top level's ports.
module erd_checker
    import erd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_run_value,
    input logic [BYTE_W-1:0] i_run_length
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_run_value)
            && $stable(i_run_length))
        else $error("run word changed while stalled");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_run_length != 8'd0)
        else $error("zero-length run word");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("run word without accepted byte");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("byte taken while run word blocked");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("run word valid after reset");

endmodule

bind escape_rle_run_decoder erd_checker u_erd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_run_value  (o_out.run_value),
    .i_run_length (o_out.run_length)
);
